FILE: hw/rtl/bgq_pkg.sv
package bgq_pkg;

	localparam int MaxBeats = 1024;
	localparam int AddrW = $clog2(MaxBeats);
	localparam int CountW = $clog2(MaxBeats + 1);

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic CFG_BEATS_PER_BAR = 1'b0;
	localparam logic CFG_INTERVAL      = 1'b1;

	localparam int QuotW = 49;
	localparam logic [17:0] PhaseMax = 18'h3FFFF;

	typedef struct packed {
		logic        go;
		logic [31:0] num_hi;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        big;
		logic [17:0] quot;
	} div_rsp_t;

endpackage

FILE: hw/rtl/bgq_div.sv
module bgq_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bgq_pkg::div_req_t req,
	output bgq_pkg::div_rsp_t rsp
);

	logic [48:0] num_q;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic [48:0] quot_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [33:0] trial;

	assign trial = {rem_q, num_q[48]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 6'd1);
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= 6'(bgq_pkg::QuotW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q  <= {1'b0, req.num_hi, 16'd0};
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[47:0], 1'b0};
			if (!trial[33]) begin
				rem_q  <= trial[32:0];
				quot_q <= {quot_q[47:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[31:0], num_q[48]};
				quot_q <= {quot_q[47:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.big  = |quot_q[48:18];
	assign rsp.quot = quot_q[17:0];

endmodule

FILE: hw/rtl/beat_grid_query.sv
// One request per start pulse; busy is high until its result strobe. Clear, append and
// unknown commands go straight to the output state. A query on a non-empty table makes one
// table read a cycle through the single read port, scanning every stored beat, then runs
// a 49-step restoring divider for the phase when the phase needs a divide; an empty table
// skips the scan. The result shows for one cycle with done high and cannot be stalled.
module beat_grid_query (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] frame,
	input  logic [23:0] tolerance_frames,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_wdata,
	output logic        done,
	output logic [3:0]  beat_in_bar,
	output logic [31:0] next_beat,
	output logic [31:0] prev_beat,
	output logic [17:0] phase,
	output logic        near_beat,
	output logic        table_full
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_LAST  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_WAIT  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic [31:0] mem [bgq_pkg::MaxBeats];
	logic [31:0] rd_q;
	logic [bgq_pkg::CountW-1:0] count_q;
	logic [bgq_pkg::CountW-1:0] idx_q;
	logic [bgq_pkg::CountW-1:0] ridx_q;
	logic [4:0]  bpb_q;
	logic [23:0] ivl_q;
	logic [1:0]  cmd_q;
	logic [31:0] frame_q;
	logic [23:0] tol_q;
	logic [31:0] next_q, prev_q, last_q, bestd_q;
	logic        nfound_q, first_seen_q;
	logic [3:0]  bib_q;
	logic [3:0]  bar_q;
	logic [3:0]  modm1;
	logic        full_q;
	logic [31:0] d;
	logic        rd_valid_q;
	bgq_pkg::div_req_t dreq;
	bgq_pkg::div_rsp_t drsp;
	logic [32:0] ext;
	logic [31:0] nxt_fin;
	logic [17:0] ph;

	assign modm1 = (bpb_q == 5'd0) ? 4'd0 : (bpb_q > 5'd16) ? 4'd15 : 4'(bpb_q - 5'd1);
	assign d = (rd_q > frame_q) ? rd_q - frame_q : frame_q - rd_q;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpb_q <= 5'd4;
			ivl_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == bgq_pkg::CFG_BEATS_PER_BAR) begin
				bpb_q <= cfg_wdata[4:0];
			end else begin
				ivl_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy && cmd == bgq_pkg::CMD_APPEND
				&& count_q < bgq_pkg::CountW'(bgq_pkg::MaxBeats)) begin
			mem[count_q[bgq_pkg::AddrW-1:0]] <= frame;
		end
		rd_q <= mem[idx_q[bgq_pkg::AddrW-1:0]];
	end

	always_comb begin
		ext = {1'b0, last_q} + {9'd0, ivl_q};
		nxt_fin = nfound_q ? next_q : (ext[32] ? 32'hFFFFFFFF : ext[31:0]);
		dreq.go = (state_q == ST_DIV) && (nxt_fin > prev_q) && (frame_q > prev_q);
		dreq.num_hi = frame_q - prev_q;
		dreq.den = {1'b0, nxt_fin - prev_q};
		ph = drsp.big ? bgq_pkg::PhaseMax : drsp.quot;
	end

	bgq_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done    <= 1'b0;
			idx_q   <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd; frame_q <= frame; tol_q <= tolerance_frames;
						full_q <= 1'b0;
						next_q <= frame; prev_q <= frame; last_q <= frame;
						nfound_q <= 1'b1; first_seen_q <= 1'b0;
						bib_q <= '0; bar_q <= '0; idx_q <= '0; ridx_q <= '0;
						phase <= '0;
						rd_valid_q <= 1'b0;
						if (cmd == bgq_pkg::CMD_CLEAR) begin
							count_q <= '0;
							state_q <= ST_OUT;
						end else if (cmd == bgq_pkg::CMD_APPEND) begin
							if (count_q < bgq_pkg::CountW'(bgq_pkg::MaxBeats)) begin
								count_q <= count_q + 1'b1;
							end else begin
								full_q <= 1'b1;
							end
							state_q <= ST_OUT;
						end else if (cmd == bgq_pkg::CMD_QUERY) begin
							if (count_q == '0) begin
								state_q <= ST_DIV;
							end else begin
								nfound_q <= 1'b0;
								idx_q <= bgq_pkg::CountW'(1);
								state_q <= ST_SCAN;
								rd_valid_q <= 1'b1;
							end
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SCAN: begin
					if (rd_valid_q) begin
						if (!first_seen_q) begin
							first_seen_q <= 1'b1;
							bestd_q <= d; bib_q <= '0;
							prev_q <= rd_q;
						end else if (d < bestd_q) begin
							bestd_q <= d; bib_q <= bar_q;
						end
						if (first_seen_q && rd_q < frame_q) begin
							prev_q <= rd_q;
						end else if (!first_seen_q && rd_q < frame_q) begin
							prev_q <= rd_q;
						end
						if (!nfound_q && rd_q > frame_q) begin
							nfound_q <= 1'b1; next_q <= rd_q;
						end
						last_q <= rd_q;
						bar_q <= (bar_q == modm1) ? 4'd0 : bar_q + 4'd1;
						ridx_q <= ridx_q + 1'b1;
						if (ridx_q + 1'b1 == count_q) begin
							rd_valid_q <= 1'b0;
							state_q <= ST_LAST;
						end
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_LAST: begin
					idx_q <= '0;
					if (ivl_q == '0) begin
						bib_q <= '0;
					end
					if (!nfound_q) begin
						next_q <= nxt_fin;
						nfound_q <= 1'b1;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= dreq.go ? ST_WAIT : ST_OUT;
				end
				ST_WAIT: begin
					if (drsp.done) begin
						phase <= ph;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		beat_in_bar = '0; next_beat = '0; prev_beat = '0;
		near_beat = 1'b0; table_full = 1'b0;
		if (done) begin
			if (cmd_q == bgq_pkg::CMD_QUERY) begin
				beat_in_bar = bib_q;
				next_beat = next_q;
				prev_beat = prev_q;
				near_beat = (((next_q > frame_q) ? next_q - frame_q : frame_q - next_q)
					< {8'd0, tol_q});
			end else if (cmd_q == bgq_pkg::CMD_APPEND) begin
				table_full = full_q;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy));
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bgq_pkg::CountW'(bgq_pkg::MaxBeats)) else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == ST_WAIT) else $error("stray divide");

endmodule
